// File: rtl/core/timestamp_sorted_event_list_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timestamp-sorted event list
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_SORTED_EVENT_LIST_DEFINES_SVH
`define TIMESTAMP_SORTED_EVENT_LIST_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define TSEL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tsel assertion failed");
// Property checked on every clock edge, reset included.
`define TSEL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("tsel assertion failed");
`else
`define TSEL_ASSERT(lbl, clk, rst_n, prop)
`define TSEL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/core/tsel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsel_pkg
// Types and constants shared by the event list cells, merge tree and top.
// ----------------------------------------------------------------------------
package tsel_pkg;

  // List geometry.
  localparam int LIST_DEPTH = 256;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // Field widths of an item and of a result.
  localparam int TIME_W   = 32;
  localparam int KIND_W   = 2;
  localparam int DRUM_W   = 5;
  localparam int VEL_W    = 7;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 8;
  localparam int COUNT_W  = 9;

  // First level of the result merge tree.
  localparam int GRP_SIZE = 16;
  localparam int N_GRP    = (LIST_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } tsel_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } tsel_status_t;

  localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CTRL     = 2'd2;

  // One stored event.
  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic [KIND_W-1:0] kind;
    logic [DRUM_W-1:0] drum;
    logic [VEL_W-1:0]  vel;
  } tsel_entry_t;

  // A cell's contribution to a lookup result; zero unless it is the hit.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    tsel_entry_t      ent;
  } tsel_hit_t;

  // Command broadcast from the top level to every cell.
  typedef struct packed {
    logic             ins_en;
    logic             look_en;
    logic [CNT_W-1:0] count;
    tsel_entry_t      ent;
  } tsel_ctl_t;

endpackage

// File: rtl/core/tsel_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsel_cell
// One slot of the sorted list: compares its entry with the key, shifts up
// on insert and flags itself as the lookup hit.
// ----------------------------------------------------------------------------
module tsel_cell (
  input  logic                      clk,
  input  tsel_pkg::tsel_ctl_t       ctl_i,
  input  logic [tsel_pkg::IDX_W-1:0] idx_i,
  input  tsel_pkg::tsel_entry_t     prev_ent_i,
  input  logic                      prev_ge_i,
  input  logic                      prev_g_i,
  output tsel_pkg::tsel_entry_t     ent_o,
  output logic                      ge_o,
  output logic                      g_o,
  output tsel_pkg::tsel_hit_t       hit_o
);
  import tsel_pkg::*;

  tsel_entry_t      ent_r, ent_nxt;
  tsel_hit_t        hit_r, hit_nxt;
  logic [CNT_W-1:0] pos;
  logic             occupied, last, ge, g, load;

  // Position of this slot against the fill count.
  assign pos      = CNT_W'(idx_i);
  assign occupied = pos < ctl_i.count;
  assign last     = (pos + CNT_W'(1)) == ctl_i.count;

  // The stored time is not below the key; monotone along the list.
  assign ge = occupied && (ent_r.ev_time >= ctl_i.ent.ev_time);
  // Lookup candidate: at or after the key, or the last stored entry.
  assign g  = occupied && (ge || last);

  // On insert, this slot and all above the insert point move up by one.
  assign load    = ctl_i.ins_en && (ge || (pos == ctl_i.count));
  assign ent_nxt = prev_ge_i ? prev_ent_i : ctl_i.ent;

  // Only the first candidate in the chain reports its entry.
  always_comb begin
    hit_nxt = '0;
    if (ctl_i.look_en && g && !prev_g_i) begin
      hit_nxt.idx = idx_i;
      hit_nxt.ent = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= ent_nxt;
    end
    hit_r <= hit_nxt;
  end

  assign ent_o = ent_r;
  assign ge_o  = ge;
  assign g_o   = g;
  assign hit_o = hit_r;

endmodule

// File: rtl/core/tsel_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsel_merge
// Registered OR tree that collects the single lookup hit from all cells.
// ----------------------------------------------------------------------------
module tsel_merge (
  input  logic                clk,
  input  tsel_pkg::tsel_hit_t hits_i [tsel_pkg::LIST_DEPTH],
  output tsel_pkg::tsel_hit_t merged_o
);
  import tsel_pkg::*;

  tsel_hit_t grp_r   [N_GRP];
  tsel_hit_t grp_nxt [N_GRP];

  // First level: OR each group of cells; at most one cell is nonzero.
  always_comb begin
    for (int j = 0; j < N_GRP; j++) begin
      grp_nxt[j] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (j * GRP_SIZE + k < LIST_DEPTH) begin
          grp_nxt[j] = grp_nxt[j] | hits_i[j * GRP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  // Second level: OR of the group registers.
  always_comb begin
    merged_o = '0;
    for (int j = 0; j < N_GRP; j++) begin
      merged_o = merged_o | grp_r[j];
    end
  end

endmodule

// File: rtl/core/timestamp_sorted_event_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_sorted_event_list
// Time-ordered list of drum events built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low. The opcode
//   selects insert, lookup, clear or no operation; insert places the event
//   ahead of stored events with the same or a later time.
//   Every item gives one result, shown on the out_ ports for exactly one
//   cycle with out_valid high. The receiver cannot stall and must take it.
// Timing:
//   busy is high while the item is in phases ph1, ph2 and ph3. In ph1 every
//   cell does the compare and the shift (insert) or hit capture (lookup);
//   ph2 and ph3 run the hit through the two levels of the merge tree into
//   the output registers. The result is on the ports once ph3 has ended,
//   with busy already low, so a new item may already be taken then; no new
//   item is taken while one is in flight, for every opcode.
// Reset:
//   rst_n is synchronous. It empties the list (count zero) and drops any item
//   in flight. The cell contents need no reset since only entries below the
//   count are ever compared or read.
// ----------------------------------------------------------------------------
`include "timestamp_sorted_event_list_defines.svh"

module timestamp_sorted_event_list (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic [tsel_pkg::KIND_W-1:0]   in_event_kind,
  input  logic [tsel_pkg::TIME_W-1:0]   in_event_time,
  input  logic [tsel_pkg::DRUM_W-1:0]   in_drum_type,
  input  logic [tsel_pkg::VEL_W-1:0]    in_velocity,
  output logic                          out_valid,
  output logic [tsel_pkg::STATUS_W-1:0] out_status,
  output logic [tsel_pkg::FOUND_W-1:0]  out_found_index,
  output logic [tsel_pkg::COUNT_W-1:0]  out_entry_count,
  output logic [tsel_pkg::TIME_W-1:0]   out_next_time,
  output logic [tsel_pkg::KIND_W-1:0]   out_next_kind,
  output logic [tsel_pkg::DRUM_W-1:0]   out_next_drum_type,
  output logic [tsel_pkg::VEL_W-1:0]    out_next_velocity
);
  import tsel_pkg::*;

  // Control state.
  logic             ph1_r, ph2_r, ph3_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;

  // Captured item and its status.
  tsel_op_t     op_r;
  tsel_entry_t  item_r, item_nxt;
  tsel_status_t status_r, status_nxt;

  // Output payload registers.
  tsel_status_t out_status_r;
  tsel_hit_t    out_hit_r;
  logic [CNT_W-1:0] out_count_r;

  logic      accept, full;
  tsel_ctl_t ctl;
  tsel_hit_t merged;

  tsel_entry_t ent_w   [LIST_DEPTH];
  logic        ge_w    [LIST_DEPTH];
  logic        g_w     [LIST_DEPTH];
  tsel_hit_t   hit_w   [LIST_DEPTH];

  assign busy   = ph1_r || ph2_r || ph3_r;
  assign accept = start && !busy;
  assign full   = count_r >= CNT_W'(LIST_DEPTH);

  // Normalize the event on capture: unknown kinds become control change,
  // note off always stores a zero velocity.
  always_comb begin
    item_nxt.ev_time = in_event_time;
    item_nxt.drum    = in_drum_type;
    item_nxt.kind    = (in_event_kind > KIND_CTRL) ? KIND_CTRL : in_event_kind;
    item_nxt.vel     = (item_nxt.kind == KIND_NOTE_OFF) ? '0 : in_velocity;
  end

  // Command to the cells, live while ph1 is high.
  always_comb begin
    ctl.ins_en  = ph1_r && (op_r == OP_INSERT) && !full;
    ctl.look_en = ph1_r && (op_r == OP_LOOKUP);
    ctl.count   = count_r;
    ctl.ent     = item_r;
  end

  // Count update and status for the item.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    unique case (op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_LOOKUP: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      OP_NOP: begin
        count_nxt = count_r;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // Phase sequencer and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph1_r       <= 1'b0;
      ph2_r       <= 1'b0;
      ph3_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ph1_r       <= accept;
      ph2_r       <= ph1_r;
      ph3_r       <= ph2_r;
      out_valid_r <= ph3_r;
      if (ph1_r) begin
        count_r <= count_nxt;
      end
    end
  end

  // Item capture and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= tsel_op_t'(in_opcode);
      item_r <= item_nxt;
    end
    if (ph1_r) begin
      status_r <= status_nxt;
    end
    if (ph3_r) begin
      out_status_r <= status_r;
      out_hit_r    <= merged;
      out_count_r  <= count_r;
    end
  end

  // Chain of cells; each takes its lower neighbor's entry on a shift.
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    tsel_entry_t prev_ent;
    logic        prev_ge, prev_g;
    if (i == 0) begin : g_head
      assign prev_ent = '0;
      assign prev_ge  = 1'b0;
      assign prev_g   = 1'b0;
    end else begin : g_body
      assign prev_ent = ent_w[i-1];
      assign prev_ge  = ge_w[i-1];
      assign prev_g   = g_w[i-1];
    end
    tsel_cell u_cell (
      .clk        (clk),
      .ctl_i      (ctl),
      .idx_i      (IDX_W'(i)),
      .prev_ent_i (prev_ent),
      .prev_ge_i  (prev_ge),
      .prev_g_i   (prev_g),
      .ent_o      (ent_w[i]),
      .ge_o       (ge_w[i]),
      .g_o        (g_w[i]),
      .hit_o      (hit_w[i])
    );
  end

  // Collect the lookup hit.
  tsel_merge u_merge (
    .clk      (clk),
    .hits_i   (hit_w),
    .merged_o (merged)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_index    = FOUND_W'(out_hit_r.idx);
  assign out_entry_count    = COUNT_W'(out_count_r);
  assign out_next_time      = out_hit_r.ent.ev_time;
  assign out_next_kind      = out_hit_r.ent.kind;
  assign out_next_drum_type = out_hit_r.ent.drum;
  assign out_next_velocity  = out_hit_r.ent.vel;

  // Checks on the sequencer and the count.
  `TSEL_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(LIST_DEPTH))
  `TSEL_ASSERT_ALWAYS(a_phase_onehot, clk, !rst_n || $onehot0({ph1_r, ph2_r, ph3_r}))
  `TSEL_ASSERT(a_result_latency, clk, rst_n, accept |-> ##4 out_valid)
  `TSEL_ASSERT(a_empty_count, clk, rst_n,
    (out_valid && (out_status == ST_EMPTY)) |-> (out_entry_count == '0))

endmodule
